/* design/ffha_pkg.sv */
// shared constants and types for the first-fit heap allocator
package ffha_pkg;
  localparam int ARENA_BYTES_D  = 16384;
  localparam int HEADER_BYTES_D = 24;
  localparam int MAX_SEGMENTS_D = 64;

  typedef enum logic [2:0] {
    ST_EXACT   = 3'd0,
    ST_SPLIT   = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_FREED   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1
  } action_t;
endpackage

/* design/ffha_ram.sv */
// generic single-port-write, single-read ram with registered read
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* design/first_fit_heap_allocator.sv */
// first-fit heap allocator: segment table in ram, a shared adder under a sequencer
//
//  channel | ports                                   | dir
//  in      | in_valid in_stall in_action             | in
//          | in_byte_count in_address                |
//  out     | out_valid out_stall out_status          | out
//          | out_payload_offset                      |
//
// an allocate request walks the table entry by entry until a fit; a split then shifts the
// tail up one entry at a time and writes the two halves of the split segment.
// a free request walks to the matching entry, then compacts the whole table, merging
// neighbouring free segments. reset restores the one free segment at once.
// in_stall is high while a request is in work or its result waits untaken.
module first_fit_heap_allocator #(
  parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_D,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_D,
  parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [13:0] in_byte_count,
  input  logic [14:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [13:0] out_payload_offset
);
  import ffha_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = 14 > $clog2(ARENA_BYTES) ? 14 : $clog2(ARENA_BYTES);
  localparam int DW = SW + 1;
  // wide enough for running header offsets and request-plus-header sums
  localparam int OW = SW + 2;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_RD       = 12'b000000000010,
    S_CHK      = 12'b000000000100,
    S_SHRD     = 12'b000000001000,
    S_SHWR     = 12'b000000010000,
    S_SPLIT    = 12'b000000100000,
    S_SPLIT_LO = 12'b000001000000,
    S_CRD      = 12'b000010000000,
    S_CHEAD    = 12'b000100000000,
    S_CSTEP    = 12'b001000000000,
    S_CFLUSH   = 12'b010000000000,
    S_OUT      = 12'b100000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   wi_r, wi_nxt;
  logic [OW-1:0]   hdr_r, hdr_nxt;
  logic            act_r, act_nxt;
  logic [13:0]     req_r, req_nxt;
  logic [14:0]     addr_r, addr_nxt;
  logic [SW-1:0]   sz_r, sz_nxt;
  logic [SW-1:0]   wsz_r, wsz_nxt;
  logic            wfree_r, wfree_nxt;
  logic [AW-1:0]   tgt_r, tgt_nxt;
  logic [2:0]      st_r, st_nxt;
  logic [13:0]     off_r, off_nxt;
  logic            e0_r, e0_nxt;    // entry 0 still holds its reset value
  logic            rd0_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [DW-1:0]   wr_data, rd_raw, rd_data;
  logic [SW-1:0]   rd_sz;
  logic            rd_fr;
  logic [OW-1:0]   add_a;
  logic [OW-1:0]   sum;

  ffha_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_raw)
  );

  // entry 0 reads as the reset segment until first written
  always_ff @(posedge clk) rd0_r <= (rd_addr == '0) && e0_r;
  assign rd_data = rd0_r ? {1'b1, SW'(ARENA_BYTES - HEADER_BYTES)} : rd_raw;
  assign rd_fr = rd_data[DW-1];
  assign rd_sz = rd_data[SW-1:0];

  // shared adder: running offset or merge head, plus header plus segment size
  assign add_a = (state_r == S_CSTEP) ? OW'(wsz_r) : hdr_r;
  assign sum   = add_a + OW'(HEADER_BYTES) + OW'(rd_sz);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_payload_offset = off_r;

  // sequencer
  always_comb begin
    logic [OW-1:0] need;
    state_nxt = state_r; count_nxt = count_r; idx_nxt = idx_r; wi_nxt = wi_r;
    hdr_nxt = hdr_r; act_nxt = act_r; req_nxt = req_r; addr_nxt = addr_r;
    sz_nxt = sz_r; wsz_nxt = wsz_r; wfree_nxt = wfree_r; tgt_nxt = tgt_r;
    st_nxt = st_r; off_nxt = off_r; e0_nxt = e0_r;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = idx_r[AW-1:0];
    need = OW'(req_r) + OW'(HEADER_BYTES);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action; req_nxt = in_byte_count; addr_nxt = in_address;
          idx_nxt = '0; hdr_nxt = '0; off_nxt = '0;
          rd_addr = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // end of table, else read entry idx
        if (idx_r >= count_r) begin
          st_nxt = (act_r == ACT_ALLOC[0]) ? ST_NOMEM : ST_INVALID;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (act_r == ACT_ALLOC[0]) begin
          if (rd_fr && (OW'(rd_sz) == OW'(req_r))) begin
            wr_en = 1'b1; wr_addr = idx_r[AW-1:0]; wr_data = {1'b0, rd_sz};
            if (idx_r == '0) e0_nxt = 1'b0;
            st_nxt = ST_EXACT;
            off_nxt = 14'(hdr_r + OW'(HEADER_BYTES));
            state_nxt = S_OUT;
          end else if (rd_fr && (OW'(rd_sz) > need) && (count_r < CW'(MAX_SEGMENTS))) begin
            sz_nxt = rd_sz; tgt_nxt = idx_r[AW-1:0];
            off_nxt = 14'(hdr_r + OW'(HEADER_BYTES));
            idx_nxt = count_r;
            state_nxt = S_SHRD;
          end else begin
            hdr_nxt = sum; idx_nxt = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end else begin
          if (hdr_r + OW'(HEADER_BYTES) == OW'(addr_r)) begin
            wr_en = 1'b1; wr_addr = idx_r[AW-1:0]; wr_data = {1'b1, rd_sz};
            if (idx_r == '0) e0_nxt = 1'b0;
            state_nxt = S_CRD;
          end else begin
            hdr_nxt = sum; idx_nxt = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_SHRD: begin
        // move entry idx-1 up to idx, from the top down to tgt+1
        if (idx_r == CW'(tgt_r) + CW'(1)) begin
          state_nxt = S_SPLIT;
        end else begin
          rd_addr = AW'(idx_r - CW'(1));
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        wr_en = 1'b1; wr_addr = idx_r[AW-1:0]; wr_data = rd_data;
        idx_nxt = idx_r - CW'(1);
        state_nxt = S_SHRD;
      end
      S_SPLIT: begin
        // remainder becomes a free segment after the target
        wr_en = 1'b1; wr_addr = AW'(CW'(tgt_r) + CW'(1));
        wr_data = {1'b1, SW'(OW'(sz_r) - need)};
        state_nxt = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        // allocated part keeps the target slot
        wr_en = 1'b1; wr_addr = tgt_r; wr_data = {1'b0, SW'(req_r)};
        if (tgt_r == '0) e0_nxt = 1'b0;
        count_nxt = count_r + CW'(1);
        st_nxt = ST_SPLIT;
        state_nxt = S_OUT;
      end
      S_CRD: begin
        // read entry 0 as the first merge head
        rd_addr = '0;
        state_nxt = S_CHEAD;
      end
      S_CHEAD: begin
        wsz_nxt = rd_sz; wfree_nxt = rd_fr; wi_nxt = '0;
        if (count_r == CW'(1)) begin
          state_nxt = S_CFLUSH;
        end else begin
          idx_nxt = CW'(1);
          rd_addr = AW'(1);
          state_nxt = S_CSTEP;
        end
      end
      S_CSTEP: begin
        // rd_data is entry idx; merge into the head or write the head back
        if (wfree_r && rd_fr) begin
          wsz_nxt = SW'(sum);
        end else begin
          wr_en = 1'b1; wr_addr = wi_r[AW-1:0]; wr_data = {wfree_r, wsz_r};
          if (wi_r == '0) e0_nxt = 1'b0;
          wi_nxt = wi_r + CW'(1);
          wsz_nxt = rd_sz; wfree_nxt = rd_fr;
        end
        if (idx_r + CW'(1) >= count_r) begin
          state_nxt = S_CFLUSH;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_addr = AW'(idx_r + CW'(1));
        end
      end
      S_CFLUSH: begin
        // write the last merge head and shrink the table
        wr_en = 1'b1; wr_addr = wi_r[AW-1:0]; wr_data = {wfree_r, wsz_r};
        if (wi_r == '0) e0_nxt = 1'b0;
        count_nxt = wi_r + CW'(1);
        st_nxt = ST_FREED;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= CW'(1); e0_r <= 1'b1;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; e0_r <= e0_nxt;
    end
    idx_r <= idx_nxt; wi_r <= wi_nxt; hdr_r <= hdr_nxt; act_r <= act_nxt;
    req_r <= req_nxt; addr_r <= addr_nxt; sz_r <= sz_nxt; wsz_r <= wsz_nxt;
    wfree_r <= wfree_nxt; tgt_r <= tgt_nxt; st_r <= st_nxt; off_r <= off_nxt;
  end
endmodule

/* test/first_fit_heap_allocator_tb.sv */
// testbench for the first-fit heap allocator: segment-table prediction, random handshakes
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int ARENA   = ARENA_BYTES_D;
  localparam int HDR     = HEADER_BYTES_D;
  localparam int NSEG    = MAX_SEGMENTS_D;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    status_t     st;
    logic [13:0] off;
  } alloc_result_t;

  // shadow segment table with queue of expected results
  class heap_scoreboard;
    int            seg_size [NSEG];
    bit            seg_free [NSEG];
    int            seg_count;
    alloc_result_t due_q[$];
    int            live_q[$];
    int            errors;

    function new();
      seg_size[0] = ARENA - HDR;
      seg_free[0] = 1'b1;
      seg_count   = 1;
      errors      = 0;
    endfunction

    // merge neighbouring free segments
    function void merge_free();
      int w;
      w = 0;
      for (int r = 1; r < seg_count; r++) begin
        if (seg_free[w] && seg_free[r]) begin
          seg_size[w] += seg_size[r] + HDR;
        end else begin
          w++;
          seg_size[w] = seg_size[r];
          seg_free[w] = seg_free[r];
        end
      end
      seg_count = w + 1;
    endfunction

    // first-fit allocate
    function alloc_result_t take_bytes(int req);
      alloc_result_t res;
      int hdr_at;
      int sz;
      res.st  = ST_NOMEM;
      res.off = '0;
      hdr_at  = 0;
      for (int i = 0; i < seg_count; i++) begin
        sz = seg_size[i];
        if (seg_free[i]) begin
          if (sz == req) begin
            seg_free[i] = 1'b0;
            res.st  = ST_EXACT;
            res.off = 14'(hdr_at + HDR);
            return res;
          end
          if (sz > req + HDR && seg_count < NSEG) begin
            for (int k = seg_count; k > i + 1; k--) begin
              seg_size[k] = seg_size[k-1];
              seg_free[k] = seg_free[k-1];
            end
            seg_size[i+1] = sz - req - HDR;
            seg_free[i+1] = 1'b1;
            seg_size[i]   = req;
            seg_free[i]   = 1'b0;
            seg_count++;
            res.st  = ST_SPLIT;
            res.off = 14'(hdr_at + HDR);
            return res;
          end
        end
        hdr_at += HDR + sz;
      end
      return res;
    endfunction

    // release by payload offset
    function alloc_result_t give_back(int adr);
      alloc_result_t res;
      int hdr_at;
      res.st  = ST_INVALID;
      res.off = '0;
      hdr_at  = 0;
      for (int i = 0; i < seg_count; i++) begin
        if (hdr_at + HDR == adr) begin
          seg_free[i] = 1'b1;
          merge_free();
          res.st = ST_FREED;
          return res;
        end
        hdr_at += HDR + seg_size[i];
      end
      return res;
    endfunction

    // note an accepted request
    function void note_request(logic act, logic [13:0] cnt, logic [14:0] adr);
      alloc_result_t res;
      if (act == ACT_ALLOC[0]) begin
        res = take_bytes(int'(cnt));
        if (res.st != ST_NOMEM) live_q.push_back(int'(res.off));
      end else begin
        res = give_back(int'(adr));
        if (res.st == ST_FREED) begin
          foreach (live_q[j]) if (live_q[j] == int'(adr)) begin
            live_q.delete(j);
            break;
          end
        end
      end
      due_q.push_back(res);
    endfunction

    // compare a result with the oldest expectation
    function void check_result(logic [2:0] st, logic [13:0] off);
      alloc_result_t exp_r;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d offset=%0d", st, off);
        return;
      end
      exp_r = due_q.pop_front();
      if (st !== exp_r.st || off !== exp_r.off) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status=%0d offset=%0d, got status=%0d offset=%0d",
                   exp_r.st, exp_r.off, st, off);
      end
    endfunction

    // payload offset of any segment, free or not
    function int any_seg_offset();
      int hdr_at;
      int pick;
      hdr_at = 0;
      pick = $urandom_range(seg_count - 1);
      for (int i = 0; i < pick; i++) hdr_at += HDR + seg_size[i];
      return hdr_at + HDR;
    endfunction

    // size of some segment, to hit exact fits
    function int some_seg_size();
      return seg_size[$urandom_range(seg_count - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [13:0] in_byte_count = '0;
  logic [14:0] in_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [13:0] out_payload_offset;

  heap_scoreboard sb = new();
  int  src_idle = 0;
  int  snk_idle = 0;
  bit  hold_on  = 1'b0;
  int  quiet_cycles = 0;

  always #5 clk = ~clk;

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_byte_count(in_byte_count), .in_address(in_address),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_payload_offset(out_payload_offset)
  );

  // receiver stall
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < snk_idle);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_payload_offset);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("first_fit_heap_allocator verification failed");
      $finish;
    end
  end

  // offer one request; entered just after a rising edge
  task automatic send_request(input logic act, input logic [13:0] cnt, input logic [14:0] adr);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_byte_count <= cnt;
    in_address    <= adr;
    do @(posedge clk); while (in_stall);
    sb.note_request(act, cnt, adr);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  // one random request, mostly well formed
  task automatic random_request();
    int r;
    int sel;
    r = $urandom_range(99);
    if (r < 45 || (r < 85 && sb.live_q.size() == 0)) begin
      sel = $urandom_range(99);
      if (sel < 70)      send_request(ACT_ALLOC[0], 14'($urandom_range(200)), 15'($urandom));
      else if (sel < 88) send_request(ACT_ALLOC[0], 14'(sb.some_seg_size()), 15'($urandom));
      else               send_request(ACT_ALLOC[0], 14'($urandom_range(16383)), 15'($urandom));
    end else if (r < 85) begin
      send_request(ACT_FREE[0], 14'($urandom),
                   15'(sb.live_q[$urandom_range(sb.live_q.size() - 1)]));
    end else if (r < 92) begin
      send_request(ACT_FREE[0], 14'($urandom), 15'($urandom_range(32767)));
    end else begin
      send_request(ACT_FREE[0], 14'($urandom), 15'(sb.any_seg_offset()));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, exact fit, double free, bad offsets, zero-byte requests
    send_request(ACT_ALLOC[0], 14'd16383, 15'h7fff);
    send_request(ACT_ALLOC[0], 14'(ARENA - HDR), 15'd0);
    send_request(ACT_FREE[0], 14'h3fff, 15'(HDR));
    send_request(ACT_FREE[0], 14'd0, 15'(HDR));
    send_request(ACT_FREE[0], 14'd0, 15'd0);
    send_request(ACT_FREE[0], 14'd0, 15'h7fff);
    send_request(ACT_FREE[0], 14'd0, 15'(ARENA));
    send_request(ACT_ALLOC[0], 14'd0, 15'd0);
    send_request(ACT_ALLOC[0], 14'd100, 15'd0);
    send_request(ACT_ALLOC[0], 14'd0, 15'd0);
    send_request(ACT_FREE[0], 14'd0, 15'(HDR));
    send_request(ACT_ALLOC[0], 14'd0, 15'd0);
    send_request(ACT_FREE[0], 14'd0, 15'(2 * HDR + 100));
    send_request(ACT_FREE[0], 14'd0, 15'(HDR + 0));
    send_request(ACT_ALLOC[0], 14'd16383, 15'd0);
    drain_results();

    // phase one, with a long receiver hold-off while requests keep coming
    src_idle = 28;
    snk_idle = 82;
    hold_on <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (650) random_request();
    drain_results();

    src_idle = 82;
    snk_idle = 28;
    repeat (650) random_request();
    drain_results();

    src_idle = 0;
    snk_idle = 0;
    repeat (700) random_request();
    drain_results();

    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("first_fit_heap_allocator verification clean");
    end else begin
      $display("first_fit_heap_allocator verification failed");
    end
    $finish;
  end
endmodule

/* first_fit_heap_allocator.f */
design/ffha_pkg.sv
design/ffha_ram.sv
design/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
